@@ hdl/dlasr_pkg.sv @@
// shared types, constants and status decode for the diagnostic line receiver
package dlasr_pkg;

    localparam int unsigned TIMER_BITS_DEFAULT = 32;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned STATUS_W           = 10;
    localparam int unsigned QUIET_W            = 16;
    localparam int unsigned BYTE_BITS          = 8;

    localparam logic [QUIET_W-1:0] QUIET_GAP_RESET = 16'd3000;

    // error byte fields
    localparam logic [7:0] ERR_OTUV_MASK = 8'hC0;
    localparam logic [7:0] ERR_GND_MASK  = 8'h08;
    localparam logic [7:0] ERR_VS_MASK   = 8'h10;
    localparam logic [7:0] ERR_REG_MASK  = 8'h20;
    localparam logic [7:0] ERR_SU_MASK   = 8'h04;
    localparam logic [7:0] ERR_SV_MASK   = 8'h02;
    localparam logic [7:0] ERR_SW_MASK   = 8'h01;

    typedef enum logic {
        KIND_EDGE  = 1'b0,
        KIND_CLEAR = 1'b1
    } t_item_kind;

    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_SYNC_START = 3'd1,
        PH_SYNC_DATA  = 3'd2,
        PH_SYNC_LAST  = 3'd3,
        PH_SYNC_STOP  = 3'd4,
        PH_DATA       = 3'd5,
        PH_ERROR      = 3'd6
    } t_rx_phase;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_SAMPLE = 1'b1
    } t_back_state;

    typedef struct packed {
        t_item_kind          kind;
        logic                rising;
        logic [STATUS_W-1:0] clear_mask;
    } t_item_ctl;

    function automatic logic [STATUS_W-1:0] decode_status(input logic [7:0] e);
        logic [STATUS_W-1:0] s;
        logic                gnd;
        logic                vs;
        logic                su;
        logic                sv;
        logic                sw;
        logic [1:0]          otuv;
        s    = '0;
        gnd  = |(e & ERR_GND_MASK);
        vs   = |(e & ERR_VS_MASK);
        su   = |(e & ERR_SU_MASK);
        sv   = |(e & ERR_SV_MASK);
        sw   = |(e & ERR_SW_MASK);
        otuv = e[7:6] & ERR_OTUV_MASK[7:6];
        s[0] = su & gnd;
        s[1] = sv & gnd;
        s[2] = sw & gnd;
        s[3] = su & vs;
        s[4] = sv & vs;
        s[5] = sw & vs;
        s[6] = |(e & ERR_REG_MASK);
        case (otuv)
            2'd3: begin
                s[7] = 1'b1;
                s[8] = 1'b1;
            end
            2'd2: s[9] = 1'b1;
            2'd1: s[8] = 1'b1;
            default: ;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/dlasr_front.sv @@
// input stage: takes words, classifies them and feeds the item queue
module dlasr_front #(
    parameter int unsigned TIMER_BITS = dlasr_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [31:0]                       i_edge_time_us,
    input  logic                              i_rising,
    input  logic [dlasr_pkg::STATUS_W-1:0]    i_clear_mask,
    output logic                              o_push,
    output dlasr_pkg::t_item_ctl              o_push_ctl,
    output logic [TIMER_BITS-1:0]             o_push_time,
    input  logic                              i_q_full
);
    import dlasr_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    t_item_ctl             r_ctl;
    logic [TIMER_BITS-1:0] r_time;
    logic                  accept;

    assign o_in_stall  = r_valid & i_q_full;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_push      = r_valid & ~i_q_full;
    assign o_push_ctl  = r_ctl;
    assign o_push_time = r_time;

    always_comb begin
        n_valid = (r_valid & i_q_full) | accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl.kind       <= i_mode ? KIND_CLEAR : KIND_EDGE;
            r_ctl.rising     <= i_rising;
            r_ctl.clear_mask <= i_clear_mask;
            r_time           <= i_edge_time_us[TIMER_BITS-1:0];
        end
    end

endmodule

@@ hdl/dlasr_queue.sv @@
// short item queue between the input stage and the decoder
module dlasr_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import dlasr_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd];

    always_comb begin
        n_wr  = i_push ? PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = i_pop ? PTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (!i_push && i_pop) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

@@ hdl/dlasr_back.sv @@
// decoder: sync tracking, bit period measurement, bit sampling and status register
module dlasr_back #(
    parameter int unsigned TIMER_BITS = dlasr_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [dlasr_pkg::QUIET_W-1:0]     i_cfg_data,
    input  logic                              i_q_empty,
    input  dlasr_pkg::t_item_ctl              i_q_ctl,
    input  logic [TIMER_BITS-1:0]             i_q_time,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dlasr_pkg::STATUS_W-1:0]    o_status_flags,
    output logic                              o_frame_done,
    output logic                              o_sync_error
);
    import dlasr_pkg::*;

    localparam int unsigned TB = TIMER_BITS;

    t_back_state     r_state;
    t_back_state     n_state;
    t_rx_phase       r_phase;
    t_rx_phase       n_phase;
    logic [TB-1:0]   r_last;
    logic [TB-1:0]   n_last;
    logic [TB-1:0]   r_sync_start;
    logic [TB-1:0]   n_sync_start;
    logic [TB-1:0]   r_data_start;
    logic [TB-1:0]   n_data_start;
    logic [TB-1:0]   r_period;
    logic [TB-1:0]   n_period;
    logic [TB-1:0]   r_offset;
    logic [TB-1:0]   n_offset;
    logic [7:0]      r_shift;
    logic [7:0]      n_shift;
    logic [3:0]      r_taken;
    logic [3:0]      n_taken;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic [TB-1:0]   r_since;
    logic [TB-1:0]   n_since;
    logic            r_rise;
    logic            n_rise;
    logic [3:0]      r_cnt;
    logic [3:0]      n_cnt;
    logic [QUIET_W-1:0] r_quiet;

    logic            r_out_valid;
    logic            n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [STATUS_W-1:0] n_out_status;
    logic            r_out_done;
    logic            n_out_done;
    logic            r_out_serr;
    logic            n_out_serr;

    logic            out_free;
    logic [TB-1:0]   now;
    logic [TB-1:0]   diff;
    logic [TB-1:0]   since;
    logic [TB-1:0]   span;
    logic [TB-1:0]   dev;
    logic            width_ok;
    logic            rise;
    logic            more;
    logic [7:0]      smp_shift;
    logic [3:0]      smp_taken;

    assign o_out_valid    = r_out_valid;
    assign o_status_flags = r_out_status;
    assign o_frame_done   = r_out_done;
    assign o_sync_error   = r_out_serr;

    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign now       = i_q_time;
    assign rise      = i_q_ctl.rising;
    assign diff      = now - r_last;
    assign since     = now - r_data_start;
    assign span      = now - r_sync_start;
    assign dev       = (diff >= r_period) ? (diff - r_period) : (r_period - diff);
    assign width_ok  = dev < (r_period >> 1);
    assign more      = ~r_cnt[3] & (r_offset < r_since);
    assign smp_shift = {r_shift[6:0], ~r_rise};
    assign smp_taken = r_taken + 4'd1;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_last       = r_last;
        n_sync_start = r_sync_start;
        n_data_start = r_data_start;
        n_period     = r_period;
        n_offset     = r_offset;
        n_shift      = r_shift;
        n_taken      = r_taken;
        n_status     = r_status;
        n_since      = r_since;
        n_rise       = r_rise;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out_status = r_out_status;
        n_out_done   = r_out_done;
        n_out_serr   = r_out_serr;
        o_pop        = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_ctl.kind == KIND_CLEAR) begin
                        if (out_free) begin
                            o_pop        = 1'b1;
                            n_status     = r_status & ~i_q_ctl.clear_mask;
                            n_out_valid  = 1'b1;
                            n_out_status = r_status & ~i_q_ctl.clear_mask;
                            n_out_done   = 1'b0;
                            n_out_serr   = 1'b0;
                        end
                    end else if (r_phase == PH_DATA) begin
                        // bits are sampled over the following cycles
                        o_pop   = 1'b1;
                        n_last  = now;
                        n_since = since;
                        n_rise  = rise;
                        n_cnt   = 4'd0;
                        n_state = BK_SAMPLE;
                    end else if (out_free) begin
                        o_pop        = 1'b1;
                        n_last       = now;
                        n_out_valid  = 1'b1;
                        n_out_status = r_status;
                        n_out_done   = 1'b0;
                        n_out_serr   = 1'b0;
                        case (r_phase)
                            PH_SYNC_START: begin
                                if (!rise) begin
                                    n_phase    = PH_ERROR;
                                    n_out_serr = 1'b1;
                                end else begin
                                    n_phase = PH_SYNC_DATA;
                                end
                            end
                            PH_SYNC_DATA: begin
                                if (rise) begin
                                    n_phase    = PH_ERROR;
                                    n_out_serr = 1'b1;
                                end else begin
                                    n_period = span >> 3;
                                    n_phase  = PH_SYNC_LAST;
                                end
                            end
                            PH_SYNC_LAST: begin
                                if (!rise || !width_ok) begin
                                    n_phase    = PH_ERROR;
                                    n_out_serr = 1'b1;
                                end else begin
                                    n_phase = PH_SYNC_STOP;
                                end
                            end
                            PH_SYNC_STOP: begin
                                if (rise || !width_ok) begin
                                    n_phase    = PH_ERROR;
                                    n_out_serr = 1'b1;
                                end else begin
                                    n_data_start = now;
                                    n_offset     = r_period + (r_period >> 1);
                                    n_shift      = '0;
                                    n_taken      = '0;
                                    n_phase      = PH_DATA;
                                end
                            end
                            PH_ERROR: begin
                                n_phase = PH_SEARCH;
                            end
                            default: begin
                                if ((diff > TB'(r_quiet)) && !rise) begin
                                    n_phase      = PH_SYNC_START;
                                    n_sync_start = now;
                                end else begin
                                    n_phase = PH_SEARCH;
                                end
                            end
                        endcase
                    end
                end
            end
            BK_SAMPLE: begin
                if (more) begin
                    if (smp_taken >= 4'(BYTE_BITS)) begin
                        // last bit of the byte: rewrite status
                        if (out_free) begin
                            n_shift      = smp_shift;
                            n_taken      = smp_taken;
                            n_status     = decode_status(smp_shift);
                            n_phase      = PH_SEARCH;
                            n_out_valid  = 1'b1;
                            n_out_status = decode_status(smp_shift);
                            n_out_done   = 1'b1;
                            n_out_serr   = 1'b0;
                            n_state      = BK_IDLE;
                        end
                    end else begin
                        n_shift  = smp_shift;
                        n_taken  = smp_taken;
                        n_offset = r_offset + r_period;
                        n_cnt    = r_cnt + 4'd1;
                    end
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_done   = 1'b0;
                    n_out_serr   = 1'b0;
                    n_state      = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_phase      <= PH_SEARCH;
            r_last       <= '0;
            r_sync_start <= '0;
            r_data_start <= '0;
            r_period     <= '0;
            r_offset     <= '0;
            r_shift      <= '0;
            r_taken      <= '0;
            r_status     <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_quiet      <= QUIET_GAP_RESET;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_last       <= n_last;
            r_sync_start <= n_sync_start;
            r_data_start <= n_data_start;
            r_period     <= n_period;
            r_offset     <= n_offset;
            r_shift      <= n_shift;
            r_taken      <= n_taken;
            r_status     <= n_status;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_quiet <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_since      <= n_since;
        r_rise       <= n_rise;
        r_out_status <= n_out_status;
        r_out_done   <= n_out_done;
        r_out_serr   <= n_out_serr;
    end

endmodule

@@ hdl/diag_line_autobaud_status_receiver.sv @@
// top level of the diagnostic line autobaud status receiver
// an accepted word is registered in the input stage and written to the queue; the decoder
// pops it and registers its result word, for a data phase edge after sampling its bits
// throughput: one word per cycle while the output is not stalled, except data phase edges,
// which keep the single bit sampler busy; a 4 word queue decouples input from decoder
// reset: synchronous active low; clears phase, timestamps, status and queue, quiet gap to 3000
module diag_line_autobaud_status_receiver #(
    parameter int unsigned TIMER_BITS = dlasr_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [31:0]                       i_edge_time_us,
    input  logic                              i_rising,
    input  logic [dlasr_pkg::STATUS_W-1:0]    i_clear_mask,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dlasr_pkg::STATUS_W-1:0]    o_status_flags,
    output logic                              o_frame_done,
    output logic                              o_sync_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dlasr_pkg::QUIET_W-1:0]     i_cfg_data
);
    import dlasr_pkg::*;

    localparam int unsigned ITEM_W = $bits(t_item_ctl) + TIMER_BITS;

    logic                  push;
    t_item_ctl             push_ctl;
    logic [TIMER_BITS-1:0] push_time;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    logic [ITEM_W-1:0]     q_head;
    t_item_ctl             head_ctl;
    logic [TIMER_BITS-1:0] head_time;

    assign o_cfg_ready = 1'b1;
    assign head_ctl    = t_item_ctl'(q_head[ITEM_W-1:TIMER_BITS]);
    assign head_time   = q_head[TIMER_BITS-1:0];

    dlasr_front #(
        .TIMER_BITS(TIMER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_edge_time_us (i_edge_time_us),
        .i_rising       (i_rising),
        .i_clear_mask   (i_clear_mask),
        .o_push         (push),
        .o_push_ctl     (push_ctl),
        .o_push_time    (push_time),
        .i_q_full       (q_full)
    );

    dlasr_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctl, push_time}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    dlasr_back #(
        .TIMER_BITS(TIMER_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_q_empty      (q_empty),
        .i_q_ctl        (head_ctl),
        .i_q_time       (head_time),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status_flags (o_status_flags),
        .o_frame_done   (o_frame_done),
        .o_sync_error   (o_sync_error)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("queue read while empty");

    a_done_xor_serr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_frame_done && o_sync_error))
        else $error("frame done and sync error on one word");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_full)
        else $error("input stalled with queue space left");

endmodule
